@@ rtl/sms_pkg.sv @@
// shared constants and codes for the sorted matrix staircase search
`default_nettype none
package sms_pkg;

   localparam int MAX_ROWS = 8;
   localparam int MAX_COLS = 8;
   localparam int DEPTH    = MAX_ROWS * MAX_COLS;

   localparam int DATA_W = 32;
   localparam int ROW_W  = 3;
   localparam int COL_W  = 3;
   localparam int SIZE_W = 4;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int RCNT_W = $clog2(MAX_ROWS + 1);
   localparam int CCNT_W = $clog2(MAX_COLS + 1);
   localparam int CSR_IDX_W = 2;

   typedef enum logic {
      KIND_WRITE  = 1'b0,
      KIND_SEARCH = 1'b1
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROWS_IN_USE = 2'd0,
      CSR_COLS_IN_USE = 2'd1
   } csr_index_type;

endpackage
`default_nettype wire

@@ rtl/sorted_matrix_staircase_search.sv @@
// sorted matrix staircase search: entry store, walk sequencer and result register
//
// Holds an 8 by 8 matrix of signed 32-bit entries, rows ascending left to right
// and columns ascending top to bottom. The req channel carries items: kind 0
// writes value at (row, col), kind 1 searches for value as a key. A write gives
// no result; a search gives one item on the rsp channel (found, found_row,
// found_col, coordinates zero when not found).
// The csr channel sets rows_in_use (index 0) and cols_in_use (index 1); it is
// always ready and is to be written only while no search is in flight.
// A search is accepted, then the walk visits entries (at most rows_in_use +
// cols_in_use - 1, so 15 at 8 by 8), then the result register is loaded once
// it is free. The walk does one compare per cycle against the registered read
// port of the store, the next address being chosen from that compare.
// req_stall is high while a search runs. A finished result waits in the rsp
// register while rsp_stall is high; the next item is accepted meanwhile, and a
// second search holds its result until the register is free.
// Reset sets both sizes to 8 and empties the result register; entries are
// undefined until written.
`default_nettype none
module sorted_matrix_staircase_search (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic                          req_kind,
   input  wire logic [sms_pkg::ROW_W-1:0]     req_row,
   input  wire logic [sms_pkg::COL_W-1:0]     req_col,
   input  wire logic signed [sms_pkg::DATA_W-1:0] req_value,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic                               rsp_found,
   output logic [sms_pkg::ROW_W-1:0]          rsp_found_row,
   output logic [sms_pkg::COL_W-1:0]          rsp_found_col,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [sms_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [sms_pkg::SIZE_W-1:0]    csr_data
);
   import sms_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_HOLD
   } state_type;

   state_type          state_ff, state_in;
   logic [RCNT_W-1:0]  x_ff, x_in;
   logic [CCNT_W-1:0]  y_ff, y_in;
   logic [DATA_W-1:0]  key_ff, key_in;
   logic               hit_ff, hit_in;
   logic [SIZE_W-1:0]  rows_ff, rows_in;
   logic [SIZE_W-1:0]  cols_ff, cols_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_found_ff, rsp_found_in;
   logic [ROW_W-1:0]   rsp_row_ff, rsp_row_in;
   logic [COL_W-1:0]   rsp_col_ff, rsp_col_in;

   logic [RCNT_W-1:0]  nrows;
   logic [CCNT_W-1:0]  ncols;
   logic               out_free;
   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic [ADDR_W-1:0]  rd_addr;
   logic [DATA_W-1:0]  rd_data;
   logic [CCNT_W-1:0]  rd_col;

   // saturate the size registers to the store
   assign nrows = (32'(rows_ff) > MAX_ROWS) ? RCNT_W'(MAX_ROWS) : RCNT_W'(rows_ff);
   assign ncols = (32'(cols_ff) > MAX_COLS) ? CCNT_W'(MAX_COLS) : CCNT_W'(cols_ff);

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   assign wr_addr = ADDR_W'(req_row) * ADDR_W'(MAX_COLS) + ADDR_W'(req_col);
   // y counts one past the current column
   assign rd_col  = y_in - CCNT_W'(1);
   assign rd_addr = ADDR_W'(x_in) * ADDR_W'(MAX_COLS) + ADDR_W'(rd_col);

   always_comb begin
      state_in     = state_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      key_in       = key_ff;
      hit_in       = hit_ff;
      rows_in      = rows_ff;
      cols_in      = cols_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_found_in = rsp_found_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      wr_en        = 1'b0;

      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ROWS_IN_USE: rows_in = csr_data;
            CSR_COLS_IN_USE: cols_in = csr_data;
            default: ;
         endcase
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_kind == KIND_WRITE) begin
                  wr_en = (32'(req_row) < MAX_ROWS) && (32'(req_col) < MAX_COLS);
               end else begin
                  key_in = req_value;
                  x_in   = '0;
                  y_in   = ncols;
                  hit_in = 1'b0;
                  if (nrows == '0 || ncols == '0) begin
                     state_in = ST_HOLD;
                  end else begin
                     state_in = ST_WALK;
                  end
               end
            end
         end
         ST_WALK: begin
            if (rd_data == key_ff) begin
               hit_in   = 1'b1;
               state_in = ST_HOLD;
            end else if ($signed(rd_data) > $signed(key_ff)) begin
               y_in = y_ff - CCNT_W'(1);
               if (y_in == '0) begin
                  state_in = ST_HOLD;
               end
            end else begin
               x_in = x_ff + RCNT_W'(1);
               if (x_in == nrows) begin
                  state_in = ST_HOLD;
               end
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = hit_ff;
               rsp_row_in   = hit_ff ? ROW_W'(x_ff) : '0;
               rsp_col_in   = hit_ff ? COL_W'(y_ff - CCNT_W'(1)) : '0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rows_ff      <= SIZE_W'(MAX_ROWS);
         cols_ff      <= SIZE_W'(MAX_COLS);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rows_ff      <= rows_in;
         cols_ff      <= cols_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      x_ff         <= x_in;
      y_ff         <= y_in;
      key_ff       <= key_in;
      hit_ff       <= hit_in;
      rsp_found_ff <= rsp_found_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_col_ff   <= rsp_col_in;
   end

   sms_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_value),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_found     = rsp_found_ff;
   assign rsp_found_row = rsp_row_ff;
   assign rsp_found_col = rsp_col_ff;

   // the walk never points outside the area in use
   a_walk_in_bounds: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WALK |-> (x_ff < nrows) && (y_ff != '0) && (y_ff <= ncols))
      else $error("walk position outside the area in use");

   // a not found result carries zero coordinates
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_found_ff |-> (rsp_row_ff == '0) && (rsp_col_ff == '0))
      else $error("not found result with nonzero coordinates");

   // an accepted search item starts a walk or goes straight to the result
   a_search_starts: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_kind == KIND_SEARCH
      |=> state_ff == ST_WALK || state_ff == ST_HOLD)
      else $error("search item accepted without starting");

   // results only come out of the hold state
   a_rsp_from_hold: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_HOLD)
      else $error("result raised outside the hold state");

endmodule
`default_nettype wire

@@ rtl/sms_ram.sv @@
// generic single write port ram with registered read
`default_nettype none
module sms_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire
